### design/frba_pkg.sv
// Shared types and constants for the fenced ring buffer allocator.
// No dependencies; imported by frba_frame_queue and the top level.
`timescale 1ns / 1ps
`default_nettype none
package frba_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int POS_W       = OFFSET_BITS + 1;
  localparam int SIZE_W      = 25;
  localparam int ALIGN_W     = 5;
  localparam int FENCE_W     = 64;
  localparam int STATUS_W    = 2;
  localparam int OP_W        = 2;

  // aligned tail can reach 2^(2^ALIGN_W - 1)
  localparam int AT_W  = 1 << ALIGN_W;
  localparam int SUM_W = AT_W + 1;
  localparam int ACC_W = SUM_W + 1;

  localparam int FQ_DEPTH = 8;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam logic [POS_W-1:0] RING_MIN = POS_W'(256);
  localparam logic [POS_W-1:0] RING_CAP = POS_W'(1) << OFFSET_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FINISH = 2'd1,
    OP_FENCE  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_QUEUE_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic [FENCE_W-1:0] fence;
    logic [POS_W-1:0]   tail;
  } frame_t;

  typedef struct packed {
    logic                en;
    logic [FQ_PTR_W-1:0] addr;
    frame_t              entry;
  } fq_wr_t;

  typedef struct packed {
    logic                en;
    logic [FQ_PTR_W-1:0] addr;
  } fq_rd_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [STATUS_W-1:0]    status;
    logic [POS_W-1:0]       used;
  } result_t;

  function automatic logic [FQ_PTR_W-1:0] ptr_next(input logic [FQ_PTR_W-1:0] p);
    logic [FQ_PTR_W-1:0] n;
    n = (p == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : p + FQ_PTR_W'(1);
    return n;
  endfunction

endpackage
`default_nettype wire

### design/frba_frame_queue.sv
// Frame queue storage: one synchronous memory of fence/tail pairs.
// Depends on frba_pkg. One write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module frba_frame_queue import frba_pkg::*; (
  input  wire    clk_i,
  input  fq_wr_t wr_i,
  input  fq_rd_t rd_i,
  output frame_t rd_data_o
);

  frame_t mem [FQ_DEPTH];
  frame_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

### design/fenced_ring_buffer_allocator.sv
// Fenced ring buffer allocator, top level.
// Allocate, finish-frame and unknown items produce their result in the execute state after
// acceptance; so does a fence item on an empty queue, else it retires up to 8 frames from
// the queue, producing its result when the queue drains or a newer frame ends the walk.
// Items are handled one at a time; a stalled result holds input.
// Reset (async, rst_ni low): empty ring, empty frame queue, ring size 2^24 bytes.
`timescale 1ns / 1ps
`default_nettype none
module fenced_ring_buffer_allocator import frba_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // configuration: ring size in bytes
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire  [SIZE_W-1:0]       cfg_buffer_size_i,
  // input items
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire  [OP_W-1:0]         op_i,
  input  wire  [SIZE_W-1:0]       alloc_size_i,
  input  wire  [ALIGN_W-1:0]      align_log2_i,
  input  wire  [FENCE_W-1:0]      fence_value_i,
  // result items
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [OFFSET_BITS-1:0]  offset_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic [POS_W-1:0]        used_bytes_o
);

  state_e state_q, state_d;

  // ring state; positions are one bit wider than an offset so the tail can sit
  // exactly at the ring end
  logic [POS_W-1:0] rs_q, rs_d;
  logic [POS_W-1:0] head_q, head_d;
  logic [POS_W-1:0] tail_q, tail_d;
  logic [POS_W-1:0] used_q, used_d;
  logic [FQ_PTR_W-1:0] rptr_q, rptr_d;
  logic [FQ_PTR_W-1:0] wptr_q, wptr_d;
  logic [FQ_CNT_W-1:0] cnt_q, cnt_d;

  // captured item
  logic [OP_W-1:0]    item_op_q;
  logic [SIZE_W-1:0]  item_size_q;
  logic [ALIGN_W-1:0] item_lg_q;
  logic [FENCE_W-1:0] item_fence_q;

  // output register and a pending slot for a result that finds it occupied
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  result_t pend_q, pend_d;

  fq_wr_t fq_wr;
  fq_rd_t fq_rd;
  frame_t fq_rdata;

  logic in_accept, cfg_we, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  // an input item takes priority over a configuration write in the same cycle
  assign cfg_ready_o = (state_q == S_IDLE) && !in_valid_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign offset_o     = out_q.offset;
  assign status_o     = out_q.status;
  assign used_bytes_o = out_q.used;

  frba_frame_queue u_fq (
    .clk_i     (clk_i),
    .wr_i      (fq_wr),
    .rd_i      (fq_rd),
    .rd_data_o (fq_rdata)
  );

  // effective ring size: round up to 256 bytes, clamp to [256, 2^OFFSET_BITS]
  logic [POS_W:0]   cfg_round;
  logic [POS_W-1:0] cfg_eff;
  assign cfg_round = ((POS_W+1)'(cfg_buffer_size_i) + (POS_W+1)'(255))
                     & ~(POS_W+1)'(255);
  always_comb begin
    if (cfg_round < (POS_W+1)'(RING_MIN)) begin
      cfg_eff = RING_MIN;
    end else if (cfg_round > (POS_W+1)'(RING_CAP)) begin
      cfg_eff = RING_CAP;
    end else begin
      cfg_eff = cfg_round[POS_W-1:0];
    end
  end

  // allocate datapath: align the tail up, then test the three placements
  logic [AT_W-1:0]  a_mask, at;
  logic [SUM_W-1:0] at_end;
  logic             ring_full, at_ge_head, end_fit, low_fit, wrap_fit;
  logic [ACC_W-1:0] used_lin, used_wrap;
  logic [POS_W-1:0] used_lin_sat, used_wrap_sat;

  assign a_mask     = (AT_W'(1) << item_lg_q) - AT_W'(1);
  assign at         = (AT_W'(tail_q) + a_mask) & ~a_mask;
  assign at_end     = SUM_W'(at) + SUM_W'(item_size_q);
  assign ring_full  = (used_q >= rs_q);
  assign at_ge_head = (at >= AT_W'(head_q));
  assign end_fit    = (at_end <= SUM_W'(rs_q));
  assign low_fit    = (at_end <= SUM_W'(head_q));
  assign wrap_fit   = (item_size_q <= SIZE_W'(head_q));

  // bytes skipped for alignment, or up to the ring end on a wrap, count as used
  assign used_lin  = ACC_W'(used_q) + ACC_W'(item_size_q) + ACC_W'(at - AT_W'(tail_q));
  assign used_wrap = ACC_W'(used_q) + ACC_W'(rs_q - tail_q) + ACC_W'(item_size_q);
  assign used_lin_sat  = (used_lin  > ACC_W'(rs_q)) ? rs_q : used_lin[POS_W-1:0];
  assign used_wrap_sat = (used_wrap > ACC_W'(rs_q)) ? rs_q : used_wrap[POS_W-1:0];

  // retire datapath: distance from head forward to the frame tail
  logic [POS_W:0]   ret_dist;
  logic [POS_W-1:0] used_ret;
  logic             ret_hit;

  assign ret_hit  = (item_fence_q >= fq_rdata.fence);
  assign ret_dist = (fq_rdata.tail >= head_q)
                    ? ((POS_W+1)'(fq_rdata.tail) - (POS_W+1)'(head_q))
                    : ((POS_W+1)'(fq_rdata.tail) + (POS_W+1)'(rs_q) - (POS_W+1)'(head_q));
  assign used_ret = (used_q == '0) ? '0 :
                    (ret_dist >= (POS_W+1)'(used_q)) ? '0 :
                    (used_q - ret_dist[POS_W-1:0]);

  logic    produce;
  result_t res;

  always_comb begin
    state_d     = state_q;
    rs_d        = rs_q;
    head_d      = head_q;
    tail_d      = tail_q;
    used_d      = used_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pend_d      = pend_q;
    fq_wr       = '0;
    fq_rd       = '0;
    produce     = 1'b0;
    res         = '0;

    // a size write empties the ring and the frame queue
    if (cfg_we) begin
      rs_d   = cfg_eff;
      head_d = '0;
      tail_d = '0;
      used_d = '0;
      rptr_d = '0;
      wptr_d = '0;
      cnt_d  = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_op_q)
          OP_ALLOC: begin
            produce    = 1'b1;
            res.status = ST_OVERFLOW;
            if (!ring_full) begin
              if (at_ge_head) begin
                if (end_fit) begin
                  tail_d     = at_end[POS_W-1:0];
                  used_d     = used_lin_sat;
                  res.offset = at[OFFSET_BITS-1:0];
                  res.status = ST_OK;
                end else if (wrap_fit) begin
                  // restart at offset 0, below the head
                  tail_d     = POS_W'(item_size_q);
                  used_d     = used_wrap_sat;
                  res.status = ST_OK;
                end
              end else if (low_fit) begin
                tail_d     = at_end[POS_W-1:0];
                used_d     = used_lin_sat;
                res.offset = at[OFFSET_BITS-1:0];
                res.status = ST_OK;
              end
            end
          end
          OP_FINISH: begin
            produce = 1'b1;
            if (cnt_q >= FQ_CNT_W'(FQ_DEPTH)) begin
              res.status = ST_QUEUE_FULL;
            end else begin
              fq_wr.en          = 1'b1;
              fq_wr.addr        = wptr_q;
              fq_wr.entry.fence = item_fence_q;
              fq_wr.entry.tail  = tail_q;
              wptr_d            = ptr_next(wptr_q);
              cnt_d             = cnt_q + FQ_CNT_W'(1);
            end
          end
          OP_FENCE: begin
            if (cnt_q == '0) begin
              produce = 1'b1;
            end else begin
              // fetch the oldest frame; compare once the read lands
              fq_rd.en   = 1'b1;
              fq_rd.addr = rptr_q;
              state_d    = S_POP;
            end
          end
          default: begin
            produce = 1'b1;
          end
        endcase
      end
      S_POP: begin
        if (ret_hit) begin
          head_d = fq_rdata.tail;
          used_d = used_ret;
          rptr_d = ptr_next(rptr_q);
          cnt_d  = cnt_q - FQ_CNT_W'(1);
          if (cnt_q == FQ_CNT_W'(1)) begin
            produce = 1'b1;
          end else begin
            fq_rd.en   = 1'b1;
            fq_rd.addr = ptr_next(rptr_q);
          end
        end else begin
          produce = 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.used = used_d;
    if (produce) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_d       = res;
        state_d     = S_IDLE;
      end else begin
        pend_d  = res;
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rs_q        <= RING_CAP;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      rptr_q      <= '0;
      wptr_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rs_q        <= rs_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_op_q    <= op_i;
      item_size_q  <= alloc_size_i;
      item_lg_q    <= align_log2_i;
      item_fence_q <= fence_value_i;
    end
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FQ_CNT_W'(FQ_DEPTH))
    else $error("frame queue count above depth");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= rs_q)
    else $error("used bytes above ring size");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (cnt_q != '0))
    else $error("retire step with empty frame queue");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EXEC))
    else $error("accepted item not executed next cycle");

  a_cfg_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |-> !in_accept)
    else $error("configuration write together with an item");

endmodule
`default_nettype wire

### bench/fenced_ring_buffer_allocator_tb.sv
// Self-checking bench for fenced_ring_buffer_allocator: directed table, then random traffic
// over several ring sizes, checked against an in-bench model of the allocator.
// Depends on frba_pkg and the design top level.
`timescale 1ns / 1ps
module fenced_ring_buffer_allocator_tb;
  import frba_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_PHASES      = 6;
  localparam int ITEMS_PER_PH  = 296;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 24;
  localparam int CFG_PAUSE     = 4;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SIZE_W-1:0]  size;
    logic [ALIGN_W-1:0] align;
    logic [FENCE_W-1:0] fence;
    logic               typed;
    result_t            want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SIZE_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_op = OP_ALLOC;
  logic [SIZE_W-1:0]  in_size = '0;
  logic [ALIGN_W-1:0] in_align = '0;
  logic [FENCE_W-1:0] in_fence = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [OFFSET_BITS-1:0] out_offset;
  logic [STATUS_W-1:0]    out_status;
  logic [POS_W-1:0]       out_used;

  fenced_ring_buffer_allocator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_buffer_size_i (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .op_i              (in_op),
    .alloc_size_i      (in_size),
    .align_log2_i      (in_align),
    .fence_value_i     (in_fence),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .offset_o          (out_offset),
    .status_o          (out_status),
    .used_bytes_o      (out_used)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Allocator model state
  logic [SIZE_W-1:0]   ring_reg;
  logic [POS_W-1:0]    head_q, tail_q, used_q;
  logic [FENCE_W-1:0]  fq_fence [FQ_DEPTH];
  logic [POS_W-1:0]    fq_tail [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] fq_rd, fq_wr;
  logic [FQ_CNT_W-1:0] fq_count;

  result_t   pending_results[$];
  stim_row_t directed_rows[$];

  int send_idle = 0;
  int recv_idle = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  logic [FENCE_W-1:0] fence_issued, fence_done;

  function automatic logic [63:0] ring_bytes(input logic [SIZE_W-1:0] v);
    logic [63:0] s;
    s = (64'(v) + 64'd255) & ~64'd255;
    if (s < 64'd256) s = 64'd256;
    if (s > 64'(RING_CAP)) s = 64'(RING_CAP);
    return s;
  endfunction

  function automatic logic [FQ_PTR_W-1:0] slot_after(input logic [FQ_PTR_W-1:0] p);
    return (int'(p) >= FQ_DEPTH - 1) ? '0 : FQ_PTR_W'(int'(p) + 1);
  endfunction

  task automatic empty_ring();
    head_q   = '0;
    tail_q   = '0;
    used_q   = '0;
    fq_rd    = '0;
    fq_wr    = '0;
    fq_count = '0;
  endtask

  // Advance the model by one item and return the result it produces
  task automatic predict_allocation(input stim_row_t row, output result_t res);
    logic [63:0] rs, al, at, sz, hd, tl, used, ft, gap;
    logic ok;
    rs   = ring_bytes(ring_reg);
    sz   = 64'(row.size);
    hd   = 64'(head_q);
    tl   = 64'(tail_q);
    used = 64'(used_q);
    ok   = 1'b0;
    res.offset = '0;
    res.status = ST_OK;
    case (row.op)
      OP_ALLOC: begin
        al = 64'd1 << row.align;
        at = (tl + al - 64'd1) & ~(al - 64'd1);
        if (used >= rs) begin
          ok = 1'b0;
        end else if (at >= hd) begin
          if (at + sz <= rs) begin
            used = used + sz + (at - tl);
            tl = at + sz;
            res.offset = at[OFFSET_BITS-1:0];
            ok = 1'b1;
          end else if (sz <= hd) begin
            // wrap to start: the gap up to the ring end counts as used
            used = used + (rs - tl) + sz;
            tl = sz;
            ok = 1'b1;
          end
        end else if (at + sz <= hd) begin
          used = used + sz + (at - tl);
          tl = at + sz;
          res.offset = at[OFFSET_BITS-1:0];
          ok = 1'b1;
        end
        if (used > rs) used = rs;
        if (!ok) begin
          res.status = ST_OVERFLOW;
          res.offset = '0;
        end
      end
      OP_FINISH: begin
        if (int'(fq_count) >= FQ_DEPTH) begin
          res.status = ST_QUEUE_FULL;
        end else begin
          fq_fence[fq_wr] = row.fence;
          fq_tail[fq_wr]  = tl[POS_W-1:0];
          fq_wr    = slot_after(fq_wr);
          fq_count = fq_count + 1'b1;
        end
      end
      OP_FENCE: begin
        while (fq_count != 0 && row.fence >= fq_fence[fq_rd]) begin
          ft = 64'(fq_tail[fq_rd]);
          if (used != 0) begin
            gap  = (ft >= hd) ? (ft - hd) : (ft + rs - hd);
            used = (gap >= used) ? 64'd0 : used - gap;
          end
          hd = ft;
          fq_rd    = slot_after(fq_rd);
          fq_count = fq_count - 1'b1;
        end
      end
      default: ;
    endcase
    head_q   = hd[POS_W-1:0];
    tail_q   = tl[POS_W-1:0];
    used_q   = used[POS_W-1:0];
    res.used = used_q;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                         input logic [ALIGN_W-1:0] align, input logic [FENCE_W-1:0] fence,
                         input logic typed, input logic [OFFSET_BITS-1:0] offset,
                         input logic [STATUS_W-1:0] status, input logic [POS_W-1:0] used);
    stim_row_t r;
    r.op = op;
    r.size = size;
    r.align = align;
    r.fence = fence;
    r.typed = typed;
    r.want.offset = offset;
    r.want.status = status;
    r.want.used = used;
    directed_rows.push_back(r);
  endtask

  // Offer one item, hold it until accepted, then queue what it should produce
  task automatic send_item(input stim_row_t row);
    result_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_op    <= row.op;
    in_size  <= row.size;
    in_align <= row.align;
    in_fence <= row.fence;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    predict_allocation(row, res);
    pending_results.push_back(row.typed ? row.want : res);
  endtask

  // Write the ring size once the block has drained
  task automatic write_ring_size(input logic [SIZE_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CFG_PAUSE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cfg_writes++;
    ring_reg = v;
    empty_ring();
  endtask

  function automatic logic [FENCE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random mix of allocations, frame finishes and trailing fence retires, plus unused ops
  task automatic run_random(input int n);
    stim_row_t r;
    logic [63:0] rs;
    int pick;
    rs = ring_bytes(ring_reg);
    fence_issued = rand64() >> 2;
    fence_done   = fence_issued;
    for (int i = 0; i < n; i++) begin
      r.typed = 1'b0;
      r.want  = '0;
      r.size  = SIZE_W'($urandom);
      r.align = ALIGN_W'($urandom);
      r.fence = rand64();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        r.op = OP_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 6)       r.size = '0;
        else if (pick < 10) r.size = SIZE_W'(rs);
        else if (pick < 14) r.size = SIZE_W'($urandom);
        else if (pick < 20) r.size = SIZE_W'($urandom_range(1, 32'(rs)));
        else                r.size = SIZE_W'($urandom_range(1, 32'(rs >> 3)));
        pick = $urandom_range(0, 99);
        if (pick < 80)      r.align = ALIGN_W'($urandom_range(0, 8));
        else if (pick < 95) r.align = ALIGN_W'($urandom_range(9, 23));
        else                r.align = ALIGN_W'($urandom_range(24, 31));
      end else if (pick < 75) begin
        r.op = OP_FINISH;
        fence_issued = fence_issued + 64'($urandom_range(1, 3));
        r.fence = ($urandom_range(0, 99) < 5) ? rand64() : fence_issued;
      end else if (pick < 95) begin
        r.op = OP_FENCE;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          fence_done = fence_done + 64'($urandom_range(0, 4));
          if (fence_done > fence_issued) fence_done = fence_issued;
          r.fence = fence_done;
        end else if (pick < 90) begin
          // flush everything, including frames with stray fences
          r.fence = '1;
          fence_done = fence_issued;
        end else begin
          r.fence = rand64();
        end
      end else begin
        r.op = OP_UNUSED;
      end
      send_item(r);
    end
  endtask

  task automatic report_error(input string what, input result_t want, input result_t got);
    error_count++;
    if (error_count <= 10)
      $display("MISMATCH %s: want off=%0d st=%0d used=%0d, got off=%0d st=%0d used=%0d",
               what, want.offset, want.status, want.used, got.offset, got.status, got.used);
  endtask

  // Result side: compare each accepted result, then pick the next stall
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got.offset = out_offset;
        got.status = out_status;
        got.used   = out_used;
        if (pending_results.size() == 0) begin
          report_error("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.offset !== want.offset || got.status !== want.status ||
              got.used !== want.used)
            report_error("result", want, got);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] ring_plan [N_PHASES];
    ring_reg = SIZE_W'(RING_CAP);
    empty_ring();
    for (int k = 0; k < FQ_DEPTH; k++) begin
      fq_fence[k] = '0;
      fq_tail[k]  = '0;
    end
    ring_plan[0] = '0;
    ring_plan[1] = '1;
    ring_plan[2] = SIZE_W'(1000);
    ring_plan[3] = SIZE_W'($urandom_range(257, 4095));
    ring_plan[4] = SIZE_W'(256);
    ring_plan[5] = SIZE_W'($urandom);

    // Directed rows against the reset ring of 2^24 bytes
    add_row(OP_ALLOC, '0, 5'd0, '0, 1'b1, '0, ST_OK, '0);
    add_row(OP_ALLOC, '1, 5'd0, '0, 1'b1, '0, ST_OVERFLOW, '0);
    add_row(OP_ALLOC, SIZE_W'(RING_CAP), 5'd0, '0, 1'b1, '0, ST_OK, RING_CAP);
    // ring full: even a zero-byte request overflows
    add_row(OP_ALLOC, '0, 5'd0, '0, 1'b1, '0, ST_OVERFLOW, RING_CAP);
    add_row(OP_FINISH, '0, 5'd0, 64'd5, 1'b1, '0, ST_OK, RING_CAP);
    add_row(OP_FENCE, '0, 5'd0, 64'd4, 1'b1, '0, ST_OK, RING_CAP);
    add_row(OP_FENCE, '0, 5'd0, 64'd5, 1'b1, '0, ST_OK, '0);
    // tail at ring end: offset masks to zero
    add_row(OP_ALLOC, '0, 5'd0, '0, 1'b1, '0, ST_OK, '0);
    add_row(OP_ALLOC, SIZE_W'(100), 5'd4, '0, 1'b1, '0, ST_OK, POS_W'(100));
    add_row(OP_UNUSED, '1, '1, '1, 1'b1, '0, ST_OK, POS_W'(100));
    add_row(OP_FINISH, '0, 5'd0, 64'd10, 1'b1, '0, ST_OK, POS_W'(100));
    // wrapped region: aligned tail below head, fits and then overflows
    add_row(OP_ALLOC, SIZE_W'(200), 5'd23, '0, 1'b0, '0, ST_OK, '0);
    add_row(OP_ALLOC, SIZE_W'(1 << 23), 5'd0, '0, 1'b0, '0, ST_OK, '0);
    // fill the frame queue, then one more is dropped
    for (int k = 0; k < FQ_DEPTH; k++)
      add_row(OP_FINISH, '0, 5'd0, 64'(11 + k), 1'b0, '0, ST_OK, '0);
    add_row(OP_FENCE, '0, 5'd0, '1, 1'b0, '0, ST_OK, '0);
    // alignment beyond the ring forces a wrap
    add_row(OP_ALLOC, '0, 5'd31, '0, 1'b0, '0, ST_OK, '0);
    add_row(OP_ALLOC, SIZE_W'(RING_CAP - 1), 5'd0, '0, 1'b0, '0, ST_OK, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 25;
    recv_idle = 56;
    @(posedge clk_i);
    foreach (directed_rows[k]) send_item(directed_rows[k]);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 2) begin
        send_idle = 25;
        recv_idle = 56;
      end else if (p < 4) begin
        send_idle = 56;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_ring_size(ring_plan[p]);
      run_random(ITEMS_PER_PH);
    end

    // Drain: drop valid, wait for every result, then let the pipe settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d items, %0d results, %0d ring size writes", items_sent,
             results_seen, cfg_writes);
    $display("Ring sizes swept from the 256-byte minimum to the 2^24 cap, %0d errors",
             error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
